// File: rtl/core/pcxrle_pkg.sv
// Package for the 8-bit PCX RLE palette decoder: word types, opcodes,
// register indexes and sizing constants. No dependencies.
`timescale 1ns / 1ps

package pcxrle_pkg;

  // Palette size and its address width
  localparam int PAL_ENTRIES = 256;
  localparam int PAL_AW      = $clog2(PAL_ENTRIES);
  localparam int RGB_W       = 24;

  // A coded byte at or above this mark carries a run count in its low bits
  localparam logic [7:0] RUN_MARK = 8'hC0;

  // Opcodes of the input word
  localparam logic [1:0] OP_PAL_WRITE = 2'd0;
  localparam logic [1:0] OP_DATA      = 2'd1;
  localparam logic [1:0] OP_NEW_IMAGE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_BYTES_PER_LINE = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd2;

  // Register reset values
  localparam logic [15:0] RST_BYTES_PER_LINE = 16'd640;
  localparam logic [15:0] RST_IMAGE_WIDTH    = 16'd640;
  localparam logic [15:0] RST_IMAGE_HEIGHT   = 16'd480;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] column;
    logic [15:0] row;
    logic        padding;
    logic        last_of_item;
    logic        end_of_image;
  } out_word_t;

endpackage

// File: rtl/core/pcxrle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pcxrle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/pcx_8bit_rle_palette_decoder_core.sv
// Top level of the 8-bit PCX RLE palette decoder.
// Uses pcxrle_pkg and one pcxrle_ram instance for the palette.
`timescale 1ns / 1ps

// Decodes the RLE byte stream of an 8-bit PCX image into RGB pixels tagged
// with column, bottom-up row, padding and end-of-image flags. Palette writes,
// new-image commands, run-count and ignored bytes never stall the input. A
// literal byte reads the palette RAM, then loads the output register. A run
// value byte with count n reads the palette RAM once, then loads n pixels,
// one pixel per cycle while the output side keeps taking words; the single
// palette read port is registered and the output register holds one word.
// A new input word is taken only after the last pixel of the current one
// has been loaded into the output register, so the next word can be
// accepted while that pixel still waits to be taken. The palette has no
// reset; reading an entry never written gives an unspecified color.
module pcx_8bit_rle_palette_decoder_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcxrle_pkg::in_word_t in_data,
  // result words
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcxrle_pkg::out_word_t out_data,
  // configuration
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   awaiting_r, awaiting_nxt;
  logic [5:0]             pending_r, pending_nxt;
  logic [5:0]             remain_r, remain_nxt;
  logic                   oob_r, oob_nxt;
  logic [15:0]            col_r, col_nxt;
  logic [15:0]            line_r, line_nxt;
  logic                   done_r, done_nxt;
  logic [15:0]            bpl_r, bpl_nxt;
  logic [15:0]            width_r, width_nxt;
  logic [15:0]            height_r, height_nxt;
  logic                   out_valid_r, out_valid_nxt;
  pcxrle_pkg::out_word_t  out_data_r, out_data_nxt;

  // Palette RAM port signals
  logic                          ram_we;
  logic                          ram_re;
  logic [pcxrle_pkg::PAL_AW-1:0] ram_waddr;
  logic [pcxrle_pkg::PAL_AW-1:0] ram_raddr;
  logic [pcxrle_pkg::RGB_W-1:0]  ram_wdata;
  logic [pcxrle_pkg::RGB_W-1:0]  ram_rdata;

  // Pixel position arithmetic
  logic        in_acc;
  logic        load;
  logic [16:0] bpl_full;
  logic [16:0] height_full;
  logic [16:0] row_full;
  logic        line_end;
  logic        img_last;
  logic        wr_in_range;
  logic        rd_in_range;
  logic [23:0] pix_rgb;

  pcxrle_ram #(
    .WIDTH(pcxrle_pkg::RGB_W),
    .DEPTH(pcxrle_pkg::PAL_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Palette addressing; indexes beyond the palette are dropped on write
  // and read as black
  assign wr_in_range = ({1'b0, in_data.palette_index} <
                        9'(pcxrle_pkg::PAL_ENTRIES));
  assign rd_in_range = ({1'b0, in_data.data_byte} < 9'(pcxrle_pkg::PAL_ENTRIES));
  assign ram_waddr   = in_data.palette_index[pcxrle_pkg::PAL_AW-1:0];
  assign ram_raddr   = in_data.data_byte[pcxrle_pkg::PAL_AW-1:0];
  assign ram_wdata   = {in_data.palette_red, in_data.palette_green,
                        in_data.palette_blue};
  assign pix_rgb     = oob_r ? 24'd0 : ram_rdata;

  // Zero line length or height count as 65536
  assign bpl_full    = (bpl_r == 16'd0) ? 17'h10000 : {1'b0, bpl_r};
  assign height_full = (height_r == 16'd0) ? 17'h10000 : {1'b0, height_r};
  assign line_end    = (({1'b0, col_r} + 17'd1) >= bpl_full);
  assign img_last    = line_end && (({1'b0, line_r} + 17'd1) >= height_full);
  assign row_full    = height_full - 17'd1 - {1'b0, line_r};

  // Output register takes a new pixel when empty or being drained
  assign load = (state_r == ST_RUN) && (!out_valid_r || out_ready);

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    awaiting_nxt  = awaiting_r;
    pending_nxt   = pending_r;
    remain_nxt    = remain_r;
    oob_nxt       = oob_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    done_nxt      = done_r;
    bpl_nxt       = bpl_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        pcxrle_pkg::CFG_BYTES_PER_LINE: bpl_nxt    = cfg_wdata;
        pcxrle_pkg::CFG_IMAGE_WIDTH:    width_nxt  = cfg_wdata;
        pcxrle_pkg::CFG_IMAGE_HEIGHT:   height_nxt = cfg_wdata;
        default: ;
      endcase
    end

    // input word decode
    if (in_acc) begin
      unique case (in_data.opcode)
        pcxrle_pkg::OP_PAL_WRITE: begin
          ram_we = wr_in_range;
        end
        pcxrle_pkg::OP_DATA: begin
          if (!done_r) begin
            if (awaiting_r) begin
              awaiting_nxt = 1'b0;
              pending_nxt  = 6'd0;
              if (pending_r != 6'd0) begin
                ram_re     = 1'b1;
                oob_nxt    = !rd_in_range;
                remain_nxt = pending_r;
                state_nxt  = ST_RUN;
              end
            end else if (in_data.data_byte >= pcxrle_pkg::RUN_MARK) begin
              awaiting_nxt = 1'b1;
              pending_nxt  = in_data.data_byte[5:0];
            end else begin
              ram_re     = 1'b1;
              oob_nxt    = !rd_in_range;
              remain_nxt = 6'd1;
              state_nxt  = ST_RUN;
            end
          end
        end
        pcxrle_pkg::OP_NEW_IMAGE: begin
          awaiting_nxt = 1'b0;
          pending_nxt  = 6'd0;
          col_nxt      = 16'd0;
          line_nxt     = 16'd0;
          done_nxt     = 1'b0;
        end
        default: ;
      endcase
    end

    // output register drain
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // pixel emission
    if (load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.red          = pix_rgb[23:16];
      out_data_nxt.green        = pix_rgb[15:8];
      out_data_nxt.blue         = pix_rgb[7:0];
      out_data_nxt.column       = col_r;
      out_data_nxt.row          = row_full[15:0];
      out_data_nxt.padding      = (col_r >= width_r);
      out_data_nxt.last_of_item = (remain_r == 6'd1) || img_last;
      out_data_nxt.end_of_image = img_last;
      remain_nxt                = remain_r - 6'd1;
      if (line_end) begin
        col_nxt = 16'd0;
        if (img_last) begin
          done_nxt = 1'b1;
        end else begin
          line_nxt = line_r + 16'd1;
        end
      end else begin
        col_nxt = col_r + 16'd1;
      end
      if ((remain_r == 6'd1) || img_last) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      awaiting_r  <= 1'b0;
      pending_r   <= 6'd0;
      remain_r    <= 6'd0;
      col_r       <= 16'd0;
      line_r      <= 16'd0;
      done_r      <= 1'b0;
      bpl_r       <= pcxrle_pkg::RST_BYTES_PER_LINE;
      width_r     <= pcxrle_pkg::RST_IMAGE_WIDTH;
      height_r    <= pcxrle_pkg::RST_IMAGE_HEIGHT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      pending_r   <= pending_nxt;
      remain_r    <= remain_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
      done_r      <= done_nxt;
      bpl_r       <= bpl_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      out_valid_r <= out_valid_nxt;
    end
    oob_r      <= oob_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/core/pcxrle_checker.sv
// Port-level checks for the PCX RLE palette decoder, bound to the top level.
// Uses pcxrle_pkg.
`timescale 1ns / 1ps

module pcxrle_props (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input pcxrle_pkg::in_word_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input pcxrle_pkg::out_word_t out_data
);

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // the final pixel of an image always closes its input word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_of_image |-> out_data.last_of_item)
    else $error("end_of_image without last_of_item");

  // words other than coded data never hold up the input
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode != pcxrle_pkg::OP_DATA) |=> in_ready)
    else $error("non-data word stalled the input");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pcx_8bit_rle_palette_decoder_core pcxrle_props u_pcxrle_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/pcxrle_checker.sv
// Pixel checker for the PCX RLE palette decoder: follows register writes and
// accepted input words, predicts the pixel words and compares them in order.
// Depends on pcxrle_pkg.
`timescale 1ns / 1ps

module pcxrle_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  pcxrle_pkg::in_word_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  pcxrle_pkg::out_word_t out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  output int unsigned           pending_words,
  output int unsigned           error_count
);

  // Shadow of the decoder state
  logic [23:0] color_lut [pcxrle_pkg::PAL_ENTRIES];
  bit          run_armed;
  logic [5:0]  run_len;
  logic [15:0] col_pos;
  logic [15:0] line_pos;
  bit          image_over;

  // Shadow of the geometry registers
  logic [15:0] bpl_reg;
  logic [15:0] width_reg;
  logic [15:0] height_reg;

  // Pixel words still owed by the decoder, oldest first
  pcxrle_pkg::out_word_t pixel_q [$];
  pcxrle_pkg::out_word_t want;

  initial begin
    for (int i = 0; i < pcxrle_pkg::PAL_ENTRIES; i++) color_lut[i] = '0;
  end

  task automatic restart_image();
    run_armed  = 1'b0;
    run_len    = '0;
    col_pos    = '0;
    line_pos   = '0;
    image_over = 1'b0;
  endtask

  // One pixel at the current position, then advance column / line
  task automatic render_pixel(input logic [7:0] idx, output pcxrle_pkg::out_word_t px);
    logic [16:0] line_len;
    logic [16:0] frame_h;
    bit          line_end;
    // a zero register means the full 16-bit range
    line_len = (bpl_reg == 16'd0) ? 17'h10000 : {1'b0, bpl_reg};
    frame_h  = (height_reg == 16'd0) ? 17'h10000 : {1'b0, height_reg};
    line_end = ({1'b0, col_pos} + 17'd1) >= line_len;
    px = '0;
    {px.red, px.green, px.blue} = color_lut[idx];
    px.column       = col_pos;
    px.row          = height_reg - 16'd1 - line_pos;
    px.padding      = col_pos >= width_reg;
    px.end_of_image = line_end && (({1'b0, line_pos} + 17'd1) >= frame_h);
    if (line_end) begin
      col_pos = '0;
      if (px.end_of_image) image_over = 1'b1;
      else line_pos = line_pos + 16'd1;
    end else begin
      col_pos = col_pos + 16'd1;
    end
  endtask

  // Expected pixels for one accepted input word
  task automatic decode_word(input pcxrle_pkg::in_word_t w);
    pcxrle_pkg::out_word_t px;
    logic [5:0] left;
    case (w.opcode)
      pcxrle_pkg::OP_PAL_WRITE:
        color_lut[w.palette_index] = {w.palette_red, w.palette_green, w.palette_blue};
      pcxrle_pkg::OP_NEW_IMAGE:
        restart_image();
      pcxrle_pkg::OP_DATA: begin
        if (!image_over) begin
          if (run_armed) begin
            // run value: repeat it, dropping whatever falls past the image end
            left      = run_len;
            run_armed = 1'b0;
            run_len   = '0;
            while (left != 0) begin
              left = left - 6'd1;
              render_pixel(w.data_byte, px);
              px.last_of_item = (left == 0) || image_over;
              pixel_q.push_back(px);
              if (image_over) left = '0;
            end
          end else if (w.data_byte >= pcxrle_pkg::RUN_MARK) begin
            run_armed = 1'b1;
            run_len   = w.data_byte[5:0];
          end else begin
            render_pixel(w.data_byte, px);
            px.last_of_item = 1'b1;
            pixel_q.push_back(px);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count = error_count + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_image();
      bpl_reg     = pcxrle_pkg::RST_BYTES_PER_LINE;
      width_reg   = pcxrle_pkg::RST_IMAGE_WIDTH;
      height_reg  = pcxrle_pkg::RST_IMAGE_HEIGHT;
      error_count = 0;
      pixel_q.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          pcxrle_pkg::CFG_BYTES_PER_LINE: bpl_reg    = cfg_wdata;
          pcxrle_pkg::CFG_IMAGE_WIDTH:    width_reg  = cfg_wdata;
          pcxrle_pkg::CFG_IMAGE_HEIGHT:   height_reg = cfg_wdata;
          default: ;
        endcase
      end
      // result side
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel word: column %0d row %0d",
                 out_data.column, out_data.row);
          error_count = error_count + 1;
        end else begin
          want = pixel_q.pop_front();
          compare_field("red", 32'(want.red), 32'(out_data.red));
          compare_field("green", 32'(want.green), 32'(out_data.green));
          compare_field("blue", 32'(want.blue), 32'(out_data.blue));
          compare_field("column", 32'(want.column), 32'(out_data.column));
          compare_field("row", 32'(want.row), 32'(out_data.row));
          compare_field("padding", 32'(want.padding), 32'(out_data.padding));
          compare_field("last_of_item", 32'(want.last_of_item),
                        32'(out_data.last_of_item));
          compare_field("end_of_image", 32'(want.end_of_image),
                        32'(out_data.end_of_image));
        end
      end
      // input side
      if (in_valid && in_ready) decode_word(in_data);
    end
    pending_words = pixel_q.size();
  end

endmodule

// File: test/testbench.sv
// Top of the PCX RLE palette decoder bench: clock, reset, stimulus, geometry
// phases and verdict. Depends on pcxrle_pkg, pcxrle_checker and the core.
`timescale 1ns / 1ps

module testbench;

  // Opcode the decoder must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 23;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pcxrle_pkg::in_word_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pcxrle_pkg::out_word_t out_data;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = pcxrle_pkg::CFG_BYTES_PER_LINE;
  logic [15:0]           cfg_wdata = '0;

  int unsigned pending_words;
  int unsigned error_count;

  // Stimulus bookkeeping
  bit         calm;        // no idling on either side
  bit         squeeze;     // ask the receiver for one long hold-off
  bit         squeezed;
  int         stall_left;
  bit         run_armed;   // next data word is a run value
  bit [255:0] written;     // palette entries loaded so far
  logic [15:0] bpl, wid, hgt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pcx_8bit_rle_palette_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pcxrle_checker pixel_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .pending_words (pending_words),
    .error_count   (error_count)
  );

  // Receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (squeeze && !squeezed) begin
      squeezed   <= 1'b1;
      stall_left <= 300;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // Word with every field random, then the opcode set
  function automatic pcxrle_pkg::in_word_t noise_word(input logic [1:0] op);
    pcxrle_pkg::in_word_t w;
    w.opcode        = op;
    w.data_byte     = 8'($urandom_range(255));
    w.palette_index = 8'($urandom_range(255));
    w.palette_red   = 8'($urandom_range(255));
    w.palette_green = 8'($urandom_range(255));
    w.palette_blue  = 8'($urandom_range(255));
    return w;
  endfunction

  // Random palette index that has been loaded, at most top
  function automatic logic [7:0] pick_index(input int unsigned top);
    logic [7:0] idx;
    idx = 8'($urandom_range(top));
    while (!written[idx]) idx = 8'($urandom_range(top));
    return idx;
  endfunction

  task automatic send_word(input pcxrle_pkg::in_word_t w);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_palette(input logic [7:0] idx, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
    pcxrle_pkg::in_word_t w;
    w = noise_word(pcxrle_pkg::OP_PAL_WRITE);
    w.palette_index = idx;
    w.palette_red   = r;
    w.palette_green = g;
    w.palette_blue  = b;
    written[idx] = 1'b1;
    send_word(w);
  endtask

  // Coded byte; track whether the next one is a run value
  task automatic send_data(input logic [7:0] b);
    pcxrle_pkg::in_word_t w;
    w = noise_word(pcxrle_pkg::OP_DATA);
    w.data_byte = b;
    if (run_armed) run_armed = 1'b0;
    else if (b >= pcxrle_pkg::RUN_MARK) run_armed = 1'b1;
    send_word(w);
  endtask

  task automatic send_op(input logic [1:0] op);
    if (op == pcxrle_pkg::OP_NEW_IMAGE) run_armed = 1'b0;
    send_word(noise_word(op));
  endtask

  // Mostly well-formed literals and runs, some noise and broken runs
  task automatic random_item();
    int unsigned dice;
    dice = $urandom_range(99);
    if (dice < 8)
      send_palette(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    else if (dice < 11)
      send_op(OP_UNUSED);
    else if (dice < 15)
      send_op(pcxrle_pkg::OP_NEW_IMAGE);
    else if (run_armed)
      send_data(pick_index(255));
    else if ($urandom_range(2) == 0)
      send_data(pcxrle_pkg::RUN_MARK | 8'($urandom_range(63)));
    else
      send_data(pick_index(pcxrle_pkg::RUN_MARK - 1));
  endtask

  // Stop offering and wait until every owed pixel word has come
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_geometry(input logic [15:0] line_bytes, input logic [15:0] width,
                               input logic [15:0] height);
    cfg_we    <= 1'b1;
    cfg_index <= pcxrle_pkg::CFG_BYTES_PER_LINE;
    cfg_wdata <= line_bytes;
    @(posedge clk);
    cfg_index <= pcxrle_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_index <= pcxrle_pkg::CFG_IMAGE_HEIGHT;
    cfg_wdata <= height;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: palette extremes, literals, runs, zero run, noise, reset geometry
    send_palette(8'h00, 8'h00, 8'h00, 8'h00);
    send_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_palette(8'hBF, 8'h12, 8'h34, 8'h56);
    send_palette(8'hC0, 8'hA5, 8'h5A, 8'hC3);
    send_data(8'h00);
    send_data(8'hBF);
    send_data(8'hC0);           // zero count: the value word emits nothing
    send_data(8'hFF);
    send_data(8'hFF);           // longest run
    send_data(8'hFF);
    send_op(OP_UNUSED);
    send_data(8'hC3);           // run interrupted by noise and a palette write
    send_op(OP_UNUSED);
    send_palette(8'h55, 8'h0F, 8'hF0, 8'h3C);
    send_data(8'h55);
    send_data(8'hC5);           // new image drops the pending run
    send_op(pcxrle_pkg::OP_NEW_IMAGE);
    send_data(8'hBF);

    // Directed: tiny image, run past the end, bytes after the end ignored
    settle();
    load_geometry(16'd3, 16'd2, 16'd2);
    send_op(pcxrle_pkg::OP_NEW_IMAGE);
    send_data(8'h00);
    send_data(8'hC9);
    send_data(8'hBF);
    send_data(8'h00);
    send_data(8'hC2);
    send_data(8'h00);
    send_op(pcxrle_pkg::OP_NEW_IMAGE);
    send_data(8'hBF);

    // Random phases over several geometries, extremes first
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin bpl = 16'd0;     wid = 16'hFFFF; hgt = 16'hFFFF; end
        1: begin bpl = 16'd1;     wid = 16'd0;    hgt = 16'd0;    end
        2: begin bpl = 16'hFFFF;  wid = 16'd1;    hgt = 16'd1;    end
        3: begin bpl = 16'd6;     wid = 16'd4;    hgt = 16'd3;    end
        default: begin
          bpl = 16'($urandom_range(40, 1));
          wid = 16'($urandom_range(32'(bpl) + 2));
          hgt = 16'($urandom_range(40, 2));
        end
      endcase
      load_geometry(bpl, wid, hgt);
      calm = (phase == 3);
      if (phase == 5) squeeze = 1'b1;
      // every third phase keeps the current image going under new geometry
      if (phase % 3 != 2) send_op(pcxrle_pkg::OP_NEW_IMAGE);
      repeat (WORDS_PER_PHASE) random_item();
    end

    settle();
    if (error_count == 0 && pending_words == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: pcx_8bit_rle_palette_decoder_core.f
rtl/core/pcxrle_pkg.sv
rtl/core/pcxrle_ram.sv
rtl/core/pcx_8bit_rle_palette_decoder_core.sv
rtl/core/pcxrle_checker.sv
test/pcxrle_checker.sv
test/testbench.sv
